// File: design/lpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpp_pkg;

	localparam int unsigned LEVEL_W   = 48;
	localparam int unsigned RATE_W    = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned OUT_W     = ((LEVEL_W + 7) / 8) * 8;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_FIRST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_LAST   = 3'd4;

	// loop modes; anything above forward wrap behaves as pingpong
	localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_LOAD,
		ST_OUT,
		ST_ADV,
		ST_FIX,
		ST_CLIP
	} state_t;

endpackage

`default_nettype wire

// File: design/loop_phasor_position_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// position tvalid is registered, set once ST_OUT finds the output register free; on a trigger
// edge the divider, ST_MUL and ST_LOAD run before ST_OUT. A new item is taken only in ST_IDLE,
// after the sequencer has walked the last one through its steps, most of them on the one shared
// 49-bit add/saturate unit, with the bit-per-cycle trigger fraction divider on that same adder
// arst_n resets state, config, output valid, position, previous trigger and direction to zero

module loop_phasor_position_gen #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned TRIG_BITS = 16,
	localparam int unsigned S_TDATA_W = ((TRIG_BITS + lpp_pkg::RATE_W + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// config write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lpp_pkg::LEVEL_W-1:0]    cfg_data,
	// input items
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata fields from bit 0: trigger_sample (TRIG_BITS), step_rate (32), zero pad
	input  wire logic [S_TDATA_W-1:0]           s_axis_tdata,
	// result items
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// tdata fields from bit 0: position (48)
	output logic [lpp_pkg::OUT_W-1:0]           m_axis_tdata
);

	import lpp_pkg::*;

	localparam int unsigned L    = LEVEL_W;
	localparam int unsigned AW   = LEVEL_W + 1;      // alu operand width
	localparam int unsigned SW   = LEVEL_W + 2;      // alu raw sum width
	localparam int unsigned PW   = FRAC_BITS + RATE_W + 1;
	localparam int unsigned CNT_W = $clog2(FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);
	localparam logic signed [L-1:0] LEVEL_MAX = {1'b0, {(L-1){1'b1}}};
	localparam logic signed [L-1:0] LEVEL_MIN = {1'b1, {(L-1){1'b0}}};

	// config registers
	logic signed [L-1:0]      range_start_q, range_end_q, loop_first_q, loop_last_q;
	logic [MODE_W-1:0]        loop_mode_q;

	// block state
	logic signed [L-1:0]          level_q;
	logic signed [TRIG_BITS-1:0]  prev_trig_q;
	logic                         going_down_q;

	// per-item working registers
	logic signed [TRIG_BITS-1:0]  cur_q;
	logic signed [RATE_W-1:0]     rate_q;
	logic signed [L-1:0]          lo_q, hi_q, ls_q, le_q;
	logic [MODE_W-1:0]            mode_q;
	logic signed [AW-1:0]         span_q;
	logic                         inside_q;

	// divider and multiplier
	logic [TRIG_BITS-1:0]         rem_q, den_q;
	logic [FRAC_BITS-1:0]         quo_q;
	logic [CNT_W-1:0]             div_cnt_q;
	logic signed [PW-1:0]         prod_q;

	// output register
	logic                         out_valid_q;
	logic [L-1:0]                 out_data_q;

	state_t state_q, state_d;

	// input fields
	logic signed [TRIG_BITS-1:0]  in_trig;
	logic signed [RATE_W-1:0]     in_rate;
	assign in_trig = s_axis_tdata[TRIG_BITS-1:0];
	assign in_rate = s_axis_tdata[TRIG_BITS+RATE_W-1:TRIG_BITS];

	logic in_accept, out_free, trig_edge;
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	// rising trigger: previous at most zero, current above zero
	assign trig_edge = (prev_trig_q <= 0) && (in_trig > 0);

	// trigger fraction operands, both fit in TRIG_BITS unsigned
	logic [TRIG_BITS:0] neg_prev_w, den_w;
	assign neg_prev_w = -{prev_trig_q[TRIG_BITS-1], prev_trig_q};
	assign den_w      = {in_trig[TRIG_BITS-1], in_trig} - {prev_trig_q[TRIG_BITS-1], prev_trig_q};

	// sign-extended rate and its negation
	logic signed [AW-1:0] rate_x, rate_neg;
	assign rate_x   = {{(AW-RATE_W){rate_q[RATE_W-1]}}, rate_q};
	assign rate_neg = -rate_x;

	// reload offset: product floor-shifted by FRAC_BITS
	logic signed [RATE_W:0] offset_w;
	assign offset_w = prod_q[FRAC_BITS+RATE_W:FRAC_BITS];

	logic signed [AW-1:0] level_x;
	assign level_x = {level_q[L-1], level_q};

	// divider step operand
	logic [TRIG_BITS:0] rem_shift;
	assign rem_shift = {rem_q, 1'b0};

	logic inside_w;
	assign inside_w = (level_q >= ls_q) && (level_q <= le_q);

	// shared add/saturate unit
	logic signed [AW-1:0] alu_a, alu_b;
	logic signed [SW-1:0] alu_sum;
	logic signed [L-1:0]  alu_sat;
	logic                 alu_neg;

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_DIV: begin
				alu_a = AW'(rem_shift);
				alu_b = -AW'(den_q);
			end
			ST_LOAD: begin
				alu_a = {range_start_q[L-1], range_start_q};
				alu_b = {{(AW-RATE_W-1){offset_w[RATE_W]}}, offset_w};
			end
			ST_OUT: begin
				// loop span, up to 2^48 - 1, kept unsaturated
				alu_a = {le_q[L-1], le_q};
				alu_b = -{ls_q[L-1], ls_q};
			end
			ST_ADV: begin
				alu_a = level_x;
				alu_b = (mode_q[1] && inside_w && going_down_q) ? rate_neg : rate_x;
			end
			ST_FIX: begin
				alu_a = level_x;
				alu_b = rate_q[RATE_W-1] ? span_q : -span_q;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_sum = {alu_a[AW-1], alu_a} + {alu_b[AW-1], alu_b};
	assign alu_neg = alu_sum[SW-1];

	always_comb begin
		if (alu_sum[SW-1:L-1] == '0 || alu_sum[SW-1:L-1] == '1) begin
			alu_sat = alu_sum[L-1:0];
		end else if (alu_neg) begin
			alu_sat = LEVEL_MIN;
		end else begin
			alu_sat = LEVEL_MAX;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = trig_edge ? ST_DIV : ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_OUT;
			ST_OUT: begin
				// hold here until the output register can take the position
				if (out_free) begin
					state_d = ST_ADV;
				end
			end
			ST_ADV:  state_d = ST_FIX;
			ST_FIX:  state_d = ST_CLIP;
			ST_CLIP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// config writes, taken in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= '0;
			range_end_q   <= '0;
			loop_mode_q   <= MODE_OFF;
			loop_first_q  <= '0;
			loop_last_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RANGE_START: range_start_q <= cfg_data;
				REG_RANGE_END:   range_end_q   <= cfg_data;
				REG_LOOP_MODE:   loop_mode_q   <= cfg_data[MODE_W-1:0];
				REG_LOOP_FIRST:  loop_first_q  <= cfg_data;
				REG_LOOP_LAST:   loop_last_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// block state: position, previous trigger, pingpong direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			prev_trig_q  <= '0;
			going_down_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					// trigger reload, pingpong starts heading down
					level_q <= alu_sat;
					if (mode_q[1]) begin
						going_down_q <= 1'b1;
					end
				end
				ST_ADV: level_q <= alu_sat;
				ST_FIX: begin
					if (mode_q == MODE_FWD) begin
						// single wrap correction by the loop span
						if (!rate_q[RATE_W-1] && level_q > le_q) begin
							level_q <= alu_sat;
						end else if (rate_q[RATE_W-1] && level_q < ls_q) begin
							level_q <= alu_sat;
						end
					end else if (mode_q != MODE_OFF && inside_q) begin
						// reflect at a loop bound
						if (level_q > le_q) begin
							level_q      <= le_q;
							going_down_q <= !going_down_q;
						end else if (level_q < ls_q) begin
							level_q      <= ls_q;
							going_down_q <= !going_down_q;
						end
					end
				end
				ST_CLIP: begin
					if (level_q < lo_q) begin
						level_q <= lo_q;
					end else if (level_q > hi_q) begin
						level_q <= hi_q;
					end
					prev_trig_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					cur_q     <= in_trig;
					rate_q    <= in_rate;
					mode_q    <= loop_mode_q;
					lo_q      <= (range_start_q < range_end_q) ? range_start_q : range_end_q;
					hi_q      <= (range_start_q < range_end_q) ? range_end_q : range_start_q;
					ls_q      <= (loop_first_q < loop_last_q) ? loop_first_q : loop_last_q;
					le_q      <= (loop_first_q < loop_last_q) ? loop_last_q : loop_first_q;
					rem_q     <= neg_prev_w[TRIG_BITS-1:0];
					den_q     <= den_w[TRIG_BITS-1:0];
					div_cnt_q <= CNT_LAST;
				end
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (!alu_neg) begin
					rem_q <= alu_sum[TRIG_BITS-1:0];
				end else begin
					rem_q <= rem_shift[TRIG_BITS-1:0];
				end
				quo_q     <= {quo_q[FRAC_BITS-2:0], !alu_neg};
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
			ST_MUL: begin
				// fraction 1.q times rate
				prod_q <= PW'($signed({2'b01, quo_q})) * PW'(rate_q);
			end
			ST_OUT: span_q <= alu_sum[AW-1:0];
			ST_ADV: inside_q <= inside_w;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= level_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

`default_nettype wire
